[sv/atsc_pkg.sv]
// Shared types and constants for the adaptive threshold step counter.
// No dependencies.
package atsc_pkg;

  localparam int WINDOW_LEN_DEF = 64;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [15:0] MIN_SWING_RST = 16'd1000;
  localparam logic signed [15:0] HIST_RST = 16'sd9000;
  localparam logic signed [19:0] SUM_RST  = 20'sd90000;
  localparam logic signed [15:0] PEAK_RESTART   = -16'sd8192;
  localparam logic signed [15:0] TROUGH_RESTART = 16'sd8192;
  localparam int SMOOTH_TAPS = 10;
  localparam logic [3:0] WARMUP_DONE = 4'd9;

  // reciprocal constants: n/10 = (n*838861)>>23, n/3 = (n*43691)>>17
  localparam logic [19:0] RECIP10 = 20'd838861;
  localparam int RECIP10_SH = 23;
  localparam logic [15:0] RECIP3 = 16'd43691;
  localparam int RECIP3_SH = 17;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_NONE = 2'd0;
  localparam axis_t AXIS_X    = 2'd1;
  localparam axis_t AXIS_Y    = 2'd2;
  localparam axis_t AXIS_Z    = 2'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } triple_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SCAN, B_DRAIN, B_UPD, B_MID, B_MUL, B_FIN
  } back_state_t;

endpackage

[sv/adaptive_threshold_step_counter.sv]
// Path: an accepted sample passes front-end stages st1 and st2, the queue, and back-end
// states UPD, MID, MUL and FIN, with SCAN and DRAIN before UPD when a stored extreme leaves
// the window and the window is rescanned. The front end takes no new sample while st1 or st2
// is busy; the rescan reads the window memory one entry per cycle and is the slowest path.
// Reset (rst, synchronous): history 9000 per tap, extremes and counters zero, min_swing 1000.
// Depends on atsc_pkg, atsc_front, atsc_queue, atsc_back.
module adaptive_threshold_step_counter #(
  parameter int WINDOW_LEN = atsc_pkg::WINDOW_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        steps_total,
  output logic [1:0]         lead_axis,
  output logic               above_upper,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic [15:0]       min_swing;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  atsc_pkg::triple_t q_wdata;
  atsc_pkg::triple_t q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_swing <= atsc_pkg::MIN_SWING_RST;
    end else if (cfg_valid) begin
      min_swing <= cfg_data;
    end
  end

  atsc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .accel_x (accel_x),
    .accel_y (accel_y),
    .accel_z (accel_z),
    .q_push  (q_push),
    .q_data  (q_wdata),
    .q_full  (q_full)
  );

  atsc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  atsc_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk         (clk),
    .rst         (rst),
    .min_swing   (min_swing),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .steps_total (steps_total),
    .lead_axis   (lead_axis),
    .above_upper (above_upper)
  );

endmodule

[sv/atsc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/atsc_front.sv]
// Front end: 10-tap moving average of raw samples; first 9 pass raw.
// Depends on atsc_pkg.
module atsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   accel_x,
  input  logic signed [15:0]   accel_y,
  input  logic signed [15:0]   accel_z,
  output logic                 q_push,
  output atsc_pkg::triple_t    q_data,
  input  logic                 q_full
);

  logic signed [15:0] hist [3][atsc_pkg::SMOOTH_TAPS];
  logic signed [19:0] sum [3];
  logic signed [19:0] sum_next [3];
  logic signed [15:0] smp [3];
  logic signed [15:0] raw [3];
  logic [18:0]        mag [3];
  logic [38:0]        prod [3];
  logic [2:0]         neg;
  logic [3:0]         spos;
  logic [3:0]         warm;
  logic               bypass;
  logic               st1;
  logic               st2;
  logic               accept;
  logic signed [15:0] res [3];
  logic [15:0]        quo [3];

  assign full   = st1 | st2;
  assign accept = push & ~full;
  assign smp[0] = accel_x;
  assign smp[1] = accel_y;
  assign smp[2] = accel_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_next[a] = sum[a] - 20'(hist[a][spos]) + 20'(smp[a]);
      quo[a] = 16'(prod[a] >> atsc_pkg::RECIP10_SH);
      res[a] = bypass ? raw[a] : (neg[a] ? -$signed(quo[a]) : $signed(quo[a]));
    end
  end

  assign q_push   = st2 & ~q_full;
  assign q_data.x = res[0];
  assign q_data.y = res[1];
  assign q_data.z = res[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      st1  <= 1'b0;
      st2  <= 1'b0;
      spos <= '0;
      warm <= '0;
      for (int a = 0; a < 3; a++) begin
        sum[a] <= atsc_pkg::SUM_RST;
        for (int k = 0; k < atsc_pkg::SMOOTH_TAPS; k++) begin
          hist[a][k] <= atsc_pkg::HIST_RST;
        end
      end
    end else begin
      if (accept) begin
        for (int a = 0; a < 3; a++) begin
          hist[a][spos] <= smp[a];
          sum[a]        <= sum_next[a];
          raw[a]        <= smp[a];
        end
        bypass <= (warm < atsc_pkg::WARMUP_DONE);
        if (warm < atsc_pkg::WARMUP_DONE) begin
          warm <= warm + 4'd1;
        end
        spos <= (spos == 4'(atsc_pkg::SMOOTH_TAPS - 1)) ? '0 : spos + 4'd1;
        st1  <= 1'b1;
      end
      if (st1) begin
        for (int a = 0; a < 3; a++) begin
          prod[a] <= 39'(mag[a]) * 39'(atsc_pkg::RECIP10);
          neg[a]  <= sum[a][19];
        end
        st1 <= 1'b0;
        st2 <= 1'b1;
      end
      if (q_push) begin
        st2 <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = sum[a][19] ? 19'(-sum[a]) : 19'(sum[a]);
    end
  end

endmodule

[sv/atsc_queue.sv]
// Short FIFO between the front end and the back end.
// Depends on atsc_pkg.
module atsc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  atsc_pkg::triple_t wdata,
  output logic              full,
  input  logic              rd,
  output atsc_pkg::triple_t rdata,
  output logic              empty
);

  localparam int AW = $clog2(atsc_pkg::QUEUE_DEPTH);

  atsc_pkg::triple_t mem [atsc_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  assign full  = (cnt == (AW+1)'(atsc_pkg::QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (wr & ~full) begin
      mem[wp] <= wdata;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr & ~full) begin
        wp <= wp + 1'b1;
      end
      if (rd & ~empty) begin
        rp <= rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(wr & ~full) - (AW+1)'(rd & ~empty);
    end
  end

endmodule

[sv/atsc_back.sv]
// Back end: window store, extreme tracking with rescan, thresholds, step logic.
// Depends on atsc_pkg and atsc_ram.
module atsc_back #(
  parameter int WINDOW_LEN = atsc_pkg::WINDOW_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       min_swing,
  input  logic              q_empty,
  input  atsc_pkg::triple_t q_data,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output logic [15:0]       steps_total,
  output logic [1:0]        lead_axis,
  output logic              above_upper
);

  localparam int IW = $clog2(WINDOW_LEN);

  atsc_pkg::back_state_t state, state_next;

  logic signed [15:0] val [3];
  logic signed [15:0] peak [3];
  logic signed [15:0] trough [3];
  logic [IW-1:0]      pidx [3];
  logic [IW-1:0]      tidx [3];
  logic [2:0]         rp;
  logic [2:0]         rt;
  logic [IW-1:0]      pos;
  logic               filled;
  logic [IW-1:0]      scan_cnt;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;
  logic [15:0]        rdata [3];
  logic signed [15:0] qv [3];
  logic [2:0]         hit_p;
  logic [2:0]         hit_t;
  logic [16:0]        mag_u [3];
  logic [16:0]        mag_l [3];
  logic [2:0]         neg_u;
  logic [2:0]         neg_l;
  logic [32:0]        prod_u [3];
  logic [32:0]        prod_l [3];
  logic signed [17:0] upper [3];
  logic signed [17:0] lower [3];
  logic [16:0]        swing [3];
  logic signed [16:0] psum [3];
  logic signed [16:0] mid [3];
  logic signed [17:0] xu [3];
  logic signed [17:0] xl [3];
  logic               armed;
  logic [15:0]        tally;
  logic               ovalid;
  logic [1:0]         lead;
  logic [16:0]        best;
  logic               go_up;
  logic               go_dn;
  logic               we;
  logic [IW-1:0]      raddr;
  logic               fin_fire;
  logic signed [15:0] lv;
  logic signed [17:0] lu;
  logic signed [17:0] ll;

  assign qv[0] = q_data.x;
  assign qv[1] = q_data.y;
  assign qv[2] = q_data.z;

  for (genvar g = 0; g < 3; g++) begin : g_win
    atsc_ram #(.WIDTH(16), .DEPTH(WINDOW_LEN)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (pos),
      .wdata (qv[g]),
      .raddr (raddr),
      .rdata (rdata[g])
    );
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      hit_p[a] = filled & (pidx[a] == pos);
      hit_t[a] = filled & (tidx[a] == pos);
      psum[a]  = 17'(peak[a]) + 17'(trough[a]);
      mid[a]   = (psum[a] + $signed(17'(psum[a][16]))) >>> 1;
      xu[a]    = 18'(mid[a]) + (18'(peak[a]) <<< 1);
      xl[a]    = 18'(mid[a]) + (18'(trough[a]) <<< 1);
      upper[a] = neg_u[a] ? -$signed(18'(prod_u[a] >> atsc_pkg::RECIP3_SH))
                          : $signed(18'(prod_u[a] >> atsc_pkg::RECIP3_SH));
      lower[a] = neg_l[a] ? -$signed(18'(prod_l[a] >> atsc_pkg::RECIP3_SH))
                          : $signed(18'(prod_l[a] >> atsc_pkg::RECIP3_SH));
      swing[a] = (peak[a] > trough[a]) ? 17'(17'(peak[a]) - 17'(trough[a])) : '0;
    end
  end

  always_comb begin
    if (swing[0] > swing[1]) begin
      if (swing[0] > swing[2]) begin
        lead = atsc_pkg::AXIS_X;
        best = swing[0];
      end else begin
        lead = atsc_pkg::AXIS_Z;
        best = swing[2];
      end
    end else begin
      if (swing[1] > swing[2]) begin
        lead = atsc_pkg::AXIS_Y;
        best = swing[1];
      end else begin
        lead = atsc_pkg::AXIS_Z;
        best = swing[2];
      end
    end
    if (!(best > 17'(min_swing))) begin
      lead = atsc_pkg::AXIS_NONE;
    end
    unique case (lead)
      atsc_pkg::AXIS_X: begin lv = val[0]; lu = upper[0]; ll = lower[0]; end
      atsc_pkg::AXIS_Y: begin lv = val[1]; lu = upper[1]; ll = lower[1]; end
      atsc_pkg::AXIS_Z: begin lv = val[2]; lu = upper[2]; ll = lower[2]; end
      default:          begin lv = val[0]; lu = upper[0]; ll = lower[0]; end
    endcase
    go_up = (lead != atsc_pkg::AXIS_NONE) & (18'(lv) > lu);
    go_dn = (lead != atsc_pkg::AXIS_NONE) & (18'(lv) < ll) & (armed | go_up);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      atsc_pkg::B_IDLE: begin
        if (!q_empty) begin
          state_next = ((hit_p | hit_t) != '0) ? atsc_pkg::B_SCAN : atsc_pkg::B_UPD;
        end
      end
      atsc_pkg::B_SCAN: begin
        if (scan_cnt == IW'(WINDOW_LEN - 1)) begin
          state_next = atsc_pkg::B_DRAIN;
        end
      end
      atsc_pkg::B_DRAIN: state_next = atsc_pkg::B_UPD;
      atsc_pkg::B_UPD:   state_next = atsc_pkg::B_MID;
      atsc_pkg::B_MID:   state_next = atsc_pkg::B_MUL;
      atsc_pkg::B_MUL:   state_next = atsc_pkg::B_FIN;
      atsc_pkg::B_FIN: begin
        if (!ovalid) begin
          state_next = atsc_pkg::B_IDLE;
        end
      end
      default: state_next = atsc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    we       = 1'b0;
    raddr    = scan_cnt;
    fin_fire = 1'b0;
    unique case (state)
      atsc_pkg::B_IDLE: begin
        q_pop = ~q_empty;
        we    = ~q_empty;
      end
      atsc_pkg::B_FIN: fin_fire = ~ovalid;
      default: ;
    endcase
  end

  assign empty       = ~ovalid;
  assign above_upper = armed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= atsc_pkg::B_IDLE;
      pos      <= '0;
      filled   <= 1'b0;
      armed    <= 1'b0;
      tally    <= '0;
      ovalid   <= 1'b0;
      rd_vld   <= 1'b0;
      scan_cnt <= '0;
      for (int a = 0; a < 3; a++) begin
        peak[a]   <= '0;
        trough[a] <= '0;
        pidx[a]   <= '0;
        tidx[a]   <= '0;
      end
    end else begin
      state  <= state_next;
      rd_vld <= (state == atsc_pkg::B_SCAN);
      rd_idx <= scan_cnt;
      if (pop & ovalid) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        atsc_pkg::B_IDLE: begin
          scan_cnt <= '0;
          if (!q_empty) begin
            rp <= hit_p;
            rt <= hit_t;
            for (int a = 0; a < 3; a++) begin
              val[a] <= qv[a];
              if (hit_p[a]) peak[a]   <= atsc_pkg::PEAK_RESTART;
              if (hit_t[a]) trough[a] <= atsc_pkg::TROUGH_RESTART;
            end
          end
        end
        atsc_pkg::B_SCAN: scan_cnt <= scan_cnt + 1'b1;
        atsc_pkg::B_UPD: begin
          for (int a = 0; a < 3; a++) begin
            if (val[a] >= peak[a]) begin
              peak[a] <= val[a];
              pidx[a] <= pos;
            end
            if (val[a] <= trough[a]) begin
              trough[a] <= val[a];
              tidx[a]   <= pos;
            end
          end
          if (pos == IW'(WINDOW_LEN - 1)) begin
            pos    <= '0;
            filled <= 1'b1;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        atsc_pkg::B_MID: begin
          for (int a = 0; a < 3; a++) begin
            neg_u[a] <= xu[a][17];
            neg_l[a] <= xl[a][17];
            mag_u[a] <= xu[a][17] ? 17'(-xu[a]) : 17'(xu[a]);
            mag_l[a] <= xl[a][17] ? 17'(-xl[a]) : 17'(xl[a]);
          end
        end
        atsc_pkg::B_MUL: begin
          for (int a = 0; a < 3; a++) begin
            prod_u[a] <= 33'(mag_u[a]) * 33'(atsc_pkg::RECIP3);
            prod_l[a] <= 33'(mag_l[a]) * 33'(atsc_pkg::RECIP3);
          end
        end
        atsc_pkg::B_FIN: begin
          if (fin_fire) begin
            armed       <= (armed | go_up) & ~go_dn;
            tally       <= tally + 16'(go_dn);
            steps_total <= tally + 16'(go_dn);
            lead_axis   <= lead;
            ovalid      <= 1'b1;
          end
        end
        default: ;
      endcase
      if (rd_vld) begin
        for (int a = 0; a < 3; a++) begin
          if (rp[a] && $signed(rdata[a]) >= peak[a]) begin
            peak[a] <= $signed(rdata[a]);
            pidx[a] <= rd_idx;
          end
          if (rt[a] && $signed(rdata[a]) <= trough[a]) begin
            trough[a] <= $signed(rdata[a]);
            tidx[a]   <= rd_idx;
          end
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= IW'(WINDOW_LEN - 1))
    else $error("window position out of range");

  a_tally_fin: assert property (@(posedge clk) disable iff (rst)
    (state != atsc_pkg::B_FIN) |=> $stable(tally))
    else $error("step tally moved outside finish");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != atsc_pkg::B_IDLE) |-> !q_pop)
    else $error("queue popped while busy");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == atsc_pkg::B_SCAN) |-> (scan_cnt <= IW'(WINDOW_LEN - 1)))
    else $error("scan address out of range");

endmodule
